[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk with rst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tsbm_pkg.sv]
// ----------------------------------------------------------------------------
// tsbm_pkg
// Shared types and constants of the two-wire sensor bus master.
// ----------------------------------------------------------------------------
package tsbm_pkg;

    // Raw request codes on the input tuser field
    localparam logic [1:0] REQ_CODE_PLAIN = 2'd0;
    localparam logic [1:0] REQ_CODE_CMD   = 2'd1;
    localparam logic [1:0] REQ_CODE_READ  = 2'd2;

    localparam logic [7:0]  CMD_MSB_MASK = 8'h80;
    localparam logic [15:0] READ_LSB     = 16'h0001;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Classified request kind
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_READ  = 2'd2
    } req_kind_t;

    // Sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_START  = 9'b000000010,
        ST_CBIT   = 9'b000000100,
        ST_CACK   = 9'b000001000,
        ST_WAIT   = 9'b000010000,
        ST_FINISH = 9'b000100000,
        ST_RBIT   = 9'b001000000,
        ST_RACK   = 9'b010000000,
        ST_REND   = 9'b100000000
    } seq_state_t;

    // One classified tick, front to back
    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] cmd;
        logic       pin;
    } tick_t;

    // One result of the back end
    typedef struct packed {
        logic        line_status;
        logic [15:0] read_word;
        logic        ack_seen;
        logic        done_res;
        logic        busy_res;
        logic        data_drive_low;
        logic        sck;
    } result_t;

endpackage

[src/two_wire_sensor_bus_master.sv]
// ----------------------------------------------------------------------------
// two_wire_sensor_bus_master
// Bit-level master for a two-wire humidity/temperature sensor bus.
// ----------------------------------------------------------------------------
// Each input transfer is one half-bit tick carrying the sampled data-pin level
// and an optional request (command byte or two-byte read); each tick yields
// exactly one output transfer with the clock level, the open-drain data drive,
// busy, done, the acknowledge flag, the read word and the line level. One tick
// is taken per clock cycle while the queue has room. Each tick is written into
// the two-entry input queue; the sequencer steps on it when the output register
// is free or being taken, and its result then sits in that register until
// taken. With the output stalled the queue fills and s_tready drops
// once two ticks wait. The sequencer step is the only state loop. Requests
// while busy are ignored; request code 3 is a plain tick. The release wait
// after a command acknowledge has no timeout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_wire_sensor_bus_master
    import tsbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] cmd_byte, [8] data_pin, [15:9] zero
    input  logic [1:0]  s_tuser,  // [1:0] req_type
    // per-tick results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [0] sck, [1] data_drive_low, [2] busy_res,
                                  // [3] done_res, [4] ack_seen,
                                  // [20:5] read_word, [21] line_status,
                                  // [23:22] zero
);

    logic    q_valid;
    logic    q_ready;
    tick_t   q_tick;
    result_t res;

    // front: decode request, buffer ticks
    tsbm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (s_tuser),
        .in_cmd   (s_tdata[7:0]),
        .in_pin   (s_tdata[8]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_tick   (q_tick)
    );

    // back: bus sequencer and output register
    tsbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_tick    (q_tick),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res};

    // a finished transfer reports not busy
    `ASSERT_IMPLIES(a_done_not_busy, m_tvalid && m_tdata[3], !m_tdata[2], "done while busy")
    // every transfer ends with the clock low
    `ASSERT_IMPLIES(a_done_clk_low, m_tvalid && m_tdata[3], !m_tdata[0], "done with sck high")
    // a full queue always has a tick to offer
    `ASSERT_IMPLIES(a_full_has_data, !s_tready, q_valid, "queue full but empty")
    // a queued tick with the output free yields a result next cycle
    `ASSERT_NEXT(a_tick_to_result, q_valid && m_tready, m_tvalid, "queued tick lost")

endmodule

[src/tsbm_front.sv]
// ----------------------------------------------------------------------------
// tsbm_front
// Accepts ticks, decodes the request code and queues them for the sequencer.
// ----------------------------------------------------------------------------
module tsbm_front
    import tsbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_req,
    input  logic [7:0]  in_cmd,
    input  logic        in_pin,
    output logic        q_valid,
    input  logic        q_ready,
    output tick_t       q_tick
);

    tick_t               mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                push, pop;
    tick_t               cls;

    // request code 3 means nothing: plain tick
    always_comb
    begin
        cls.cmd = in_cmd;
        cls.pin = in_pin;
        case (in_req)
            REQ_CODE_CMD:  cls.kind = KIND_CMD;
            REQ_CODE_READ: cls.kind = KIND_READ;
            default:       cls.kind = KIND_PLAIN;
        endcase
    end

    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_tick   = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

[src/tsbm_back.sv]
// ----------------------------------------------------------------------------
// tsbm_back
// Bus sequencer: one step per tick, result held in an output register.
// ----------------------------------------------------------------------------
module tsbm_back
    import tsbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    output logic    q_ready,
    input  tick_t   q_tick,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    seq_state_t  state_reg,  state_next;
    logic [2:0]  phase_reg,  phase_next;
    logic [3:0]  bits_reg,   bits_next;
    logic [15:0] shift_reg,  shift_next;
    logic [7:0]  cmd_reg,    cmd_next;
    logic        ack_reg,    ack_next;
    logic        clk_lvl_reg, clk_lvl_next;
    logic        drv_reg,    drv_next;
    logic        done;
    logic        valid_reg;
    result_t     res_reg;
    logic        take;

    assign take      = q_valid && (!valid_reg || out_ready);
    assign q_ready   = take;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        bits_next    = bits_reg;
        shift_next   = shift_reg;
        cmd_next     = cmd_reg;
        ack_next     = ack_reg;
        clk_lvl_next = clk_lvl_reg;
        drv_next     = drv_reg;
        done         = 1'b0;

        // request only taken while idle
        if (state_reg == ST_IDLE)
        begin
            if (q_tick.kind == KIND_CMD)
            begin
                cmd_next   = q_tick.cmd;
                state_next = ST_START;
                phase_next = '0;
                bits_next  = '0;
            end
            else if (q_tick.kind == KIND_READ)
            begin
                shift_next = '0;
                state_next = ST_RBIT;
                phase_next = '0;
                bits_next  = '0;
            end
        end

        case (state_next)
            ST_IDLE:
            begin
            end
            ST_START:
            begin
                phase_next = phase_next + 3'd1;
                case (phase_next - 3'd1)
                    3'd0: clk_lvl_next = 1'b0;
                    3'd1: drv_next     = 1'b0;
                    3'd2: clk_lvl_next = 1'b1;
                    3'd3: drv_next     = 1'b1;
                    3'd4: clk_lvl_next = 1'b0;
                    3'd5: clk_lvl_next = 1'b1;
                    3'd6: drv_next     = 1'b0;
                    default:
                    begin
                        clk_lvl_next = 1'b0;
                        state_next   = ST_CBIT;
                        phase_next   = '0;
                        bits_next    = '0;
                    end
                endcase
            end
            ST_CBIT:
            begin
                if (phase_next == 3'd0)
                begin
                    drv_next   = ((cmd_next & CMD_MSB_MASK) == '0);
                    phase_next = 3'd1;
                end
                else if (phase_next == 3'd1)
                begin
                    clk_lvl_next = 1'b1;
                    cmd_next     = {cmd_next[6:0], 1'b0};
                    phase_next   = 3'd2;
                end
                else
                begin
                    clk_lvl_next = 1'b0;
                    phase_next   = '0;
                    if (bits_next >= 4'd7)
                    begin
                        bits_next  = '0;
                        state_next = ST_CACK;
                    end
                    else
                    begin
                        bits_next = bits_next + 4'd1;
                    end
                end
            end
            ST_CACK:
            begin
                if (phase_next == 3'd0)
                begin
                    drv_next   = 1'b0;
                    phase_next = 3'd1;
                end
                else if (phase_next == 3'd1)
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = 3'd2;
                end
                else if (phase_next == 3'd2)
                begin
                    if (!q_tick.pin)
                    begin
                        ack_next   = 1'b1;
                        phase_next = 3'd3;
                    end
                    else
                    begin
                        ack_next     = 1'b0;
                        clk_lvl_next = 1'b0;
                        state_next   = ST_FINISH;
                        phase_next   = '0;
                    end
                end
                else
                begin
                    clk_lvl_next = 1'b0;
                    state_next   = ST_WAIT;
                    phase_next   = '0;
                end
            end
            ST_WAIT:
            begin
                // no timeout on the release wait
                if (q_tick.pin)
                begin
                    state_next = ST_FINISH;
                    phase_next = '0;
                end
            end
            ST_FINISH:
            begin
                state_next   = ST_IDLE;
                phase_next   = '0;
                clk_lvl_next = 1'b0;
                drv_next     = 1'b0;
                done         = 1'b1;
            end
            ST_RBIT:
            begin
                if (phase_next == 3'd0)
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = 3'd1;
                end
                else
                begin
                    shift_next = {shift_next[14:0], 1'b0}
                               | (q_tick.pin ? READ_LSB : 16'h0000);
                    clk_lvl_next = 1'b0;
                    phase_next   = '0;
                    if (bits_next == 4'd7)
                    begin
                        bits_next  = 4'd8;
                        state_next = ST_RACK;
                    end
                    else if (bits_next >= 4'd15)
                    begin
                        bits_next  = '0;
                        state_next = ST_REND;
                    end
                    else
                    begin
                        bits_next = bits_next + 4'd1;
                    end
                end
            end
            ST_RACK:
            begin
                if (phase_next == 3'd0)
                begin
                    drv_next   = 1'b1;
                    phase_next = 3'd1;
                end
                else if (phase_next == 3'd1)
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = 3'd2;
                end
                else
                begin
                    clk_lvl_next = 1'b0;
                    drv_next     = 1'b0;
                    state_next   = ST_RBIT;
                    phase_next   = '0;
                end
            end
            ST_REND:
            begin
                if (phase_next == 3'd0)
                begin
                    drv_next   = 1'b0;
                    phase_next = 3'd1;
                end
                else if (phase_next == 3'd1)
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = 3'd2;
                end
                else
                begin
                    state_next   = ST_IDLE;
                    phase_next   = '0;
                    clk_lvl_next = 1'b0;
                    drv_next     = 1'b0;
                    done         = 1'b1;
                end
            end
            default:
            begin
                state_next   = ST_IDLE;
                phase_next   = '0;
                clk_lvl_next = 1'b0;
                drv_next     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            bits_reg    <= '0;
            shift_reg   <= '0;
            cmd_reg     <= '0;
            ack_reg     <= 1'b0;
            clk_lvl_reg <= 1'b0;
            drv_reg     <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg   <= state_next;
                phase_reg   <= phase_next;
                bits_reg    <= bits_next;
                shift_reg   <= shift_next;
                cmd_reg     <= cmd_next;
                ack_reg     <= ack_next;
                clk_lvl_reg <= clk_lvl_next;
                drv_reg     <= drv_next;
                valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg.sck            <= clk_lvl_next;
            res_reg.data_drive_low <= drv_next;
            res_reg.busy_res       <= (state_next != ST_IDLE);
            res_reg.done_res       <= done;
            res_reg.ack_seen       <= ack_next;
            res_reg.read_word      <= shift_next;
            res_reg.line_status    <= q_tick.pin;
        end
    end

endmodule

[tb/tsbm_tb_pkg.sv]
// ----------------------------------------------------------------------------
// tsbm_tb_pkg
// Bus-level mirror and result checker for the two-wire sensor bus master.
// ----------------------------------------------------------------------------
// Keeps its own copy of the master's sequencer, moves it one half-bit tick per
// accepted input transfer and queues the bus levels expected for that tick.
// Output transfers are then matched in order against that queue.
// ----------------------------------------------------------------------------
package tsbm_tb_pkg;

    import tsbm_pkg::*;

    // unused request code, must act as a plain tick
    localparam logic [1:0] REQ_CODE_SPARE = 2'd3;

    localparam int MAX_REPORTS = 10;

    class sensor_bus_scoreboard;

        // mirrored sequencer
        seq_state_t  seq;
        logic [2:0]  phase;
        logic [3:0]  bit_idx;
        logic [15:0] rx_word;
        logic        ack_flag;
        logic        sck_level;
        logic        pull_low;
        logic [7:0]  cmd_shreg;

        result_t     expected_bus_q[$];

        int          mismatches;
        int          results_checked;
        int          cmd_starts;
        int          read_starts;
        int          acks_taken;
        int          ignored_reqs;
        int          done_pulses;

        function new();
            seq       = ST_IDLE;
            phase     = '0;
            bit_idx   = '0;
            rx_word   = '0;
            ack_flag  = 1'b0;
            sck_level = 1'b0;
            pull_low  = 1'b0;
            cmd_shreg = '0;
        endfunction

        function void go_idle();
            seq       = ST_IDLE;
            phase     = '0;
            sck_level = 1'b0;
            pull_low  = 1'b0;
        endfunction

        // One half-bit step; returns 1 on the tick that ends a transfer.
        function bit step_sequencer(logic pin);
            case (seq)
                ST_IDLE:
                    return 1'b0;
                ST_START:
                begin
                    // start pattern: one line action per tick
                    case (phase)
                        3'd0: sck_level = 1'b0;
                        3'd1: pull_low  = 1'b0;
                        3'd2: sck_level = 1'b1;
                        3'd3: pull_low  = 1'b1;
                        3'd4: sck_level = 1'b0;
                        3'd5: sck_level = 1'b1;
                        3'd6: pull_low  = 1'b0;
                        default:
                        begin
                            sck_level = 1'b0;
                            seq       = ST_CBIT;
                            phase     = '0;
                            bit_idx   = '0;
                            return 1'b0;
                        end
                    endcase
                    phase = phase + 3'd1;
                    return 1'b0;
                end
                ST_CBIT:
                begin
                    if (phase == 3'd0) begin
                        pull_low = ~cmd_shreg[7];
                        phase    = 3'd1;
                    end else if (phase == 3'd1) begin
                        sck_level = 1'b1;
                        cmd_shreg = {cmd_shreg[6:0], 1'b0};
                        phase     = 3'd2;
                    end else begin
                        sck_level = 1'b0;
                        phase     = '0;
                        if (bit_idx >= 4'd7) begin
                            bit_idx = '0;
                            seq     = ST_CACK;
                        end else begin
                            bit_idx = bit_idx + 4'd1;
                        end
                    end
                    return 1'b0;
                end
                ST_CACK:
                begin
                    if (phase == 3'd0) begin
                        pull_low = 1'b0;
                        phase    = 3'd1;
                    end else if (phase == 3'd1) begin
                        sck_level = 1'b1;
                        phase     = 3'd2;
                    end else if (phase == 3'd2) begin
                        if (pin == 1'b0) begin
                            ack_flag = 1'b1;
                            acks_taken++;
                            phase = 3'd3;
                        end else begin
                            ack_flag  = 1'b0;
                            sck_level = 1'b0;
                            seq       = ST_FINISH;
                            phase     = '0;
                        end
                    end else begin
                        sck_level = 1'b0;
                        seq       = ST_WAIT;
                        phase     = '0;
                    end
                    return 1'b0;
                end
                ST_WAIT:
                begin
                    if (pin) begin
                        seq   = ST_FINISH;
                        phase = '0;
                    end
                    return 1'b0;
                end
                ST_FINISH:
                begin
                    go_idle();
                    return 1'b1;
                end
                ST_RBIT:
                begin
                    if (phase == 3'd0) begin
                        sck_level = 1'b1;
                        phase     = 3'd1;
                        return 1'b0;
                    end
                    rx_word   = {rx_word[14:0], pin};
                    sck_level = 1'b0;
                    phase     = '0;
                    if (bit_idx == 4'd7) begin
                        bit_idx = 4'd8;
                        seq     = ST_RACK;
                    end else if (bit_idx >= 4'd15) begin
                        bit_idx = '0;
                        seq     = ST_REND;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                    end
                    return 1'b0;
                end
                ST_RACK:
                begin
                    if (phase == 3'd0) begin
                        pull_low = 1'b1;
                        phase    = 3'd1;
                    end else if (phase == 3'd1) begin
                        sck_level = 1'b1;
                        phase     = 3'd2;
                    end else begin
                        sck_level = 1'b0;
                        pull_low  = 1'b0;
                        seq       = ST_RBIT;
                        phase     = '0;
                    end
                    return 1'b0;
                end
                ST_REND:
                begin
                    if (phase == 3'd0) begin
                        pull_low = 1'b0;
                        phase    = 3'd1;
                        return 1'b0;
                    end
                    if (phase == 3'd1) begin
                        sck_level = 1'b1;
                        phase     = 3'd2;
                        return 1'b0;
                    end
                    go_idle();
                    return 1'b1;
                end
                default:
                begin
                    go_idle();
                    return 1'b0;
                end
            endcase
        endfunction

        // Accepted input tick: advance the mirror and queue the bus levels.
        function void note_tick(logic [1:0] req, logic [7:0] cmd, logic pin);
            result_t lv;
            bit      fin;
            if (seq == ST_IDLE) begin
                if (req == REQ_CODE_CMD) begin
                    cmd_shreg = cmd;
                    seq       = ST_START;
                    phase     = '0;
                    bit_idx   = '0;
                    cmd_starts++;
                end else if (req == REQ_CODE_READ) begin
                    rx_word = '0;
                    seq     = ST_RBIT;
                    phase   = '0;
                    bit_idx = '0;
                    read_starts++;
                end
            end else if (req == REQ_CODE_CMD || req == REQ_CODE_READ) begin
                ignored_reqs++;
            end
            fin = step_sequencer(pin);
            if (fin)
                done_pulses++;
            lv.sck            = sck_level;
            lv.data_drive_low = pull_low;
            lv.busy_res       = (seq != ST_IDLE);
            lv.done_res       = fin;
            lv.ack_seen       = ack_flag;
            lv.read_word      = rx_word;
            lv.line_status    = pin;
            expected_bus_q.push_back(lv);
        endfunction

        // Accepted output tick: compare with the oldest queued levels.
        function void check_result(result_t got);
            result_t want;
            bit      bad;
            if (expected_bus_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output transfer: %h", got);
                return;
            end
            want = expected_bus_q.pop_front();
            results_checked++;
            bad = (got.sck !== want.sck) ||
                  (got.data_drive_low !== want.data_drive_low) ||
                  (got.busy_res !== want.busy_res) ||
                  (got.done_res !== want.done_res) ||
                  (got.ack_seen !== want.ack_seen) ||
                  (got.read_word !== want.read_word) ||
                  (got.line_status !== want.line_status);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("tick %0d mismatch", results_checked);
                    $display("  exp sck=%b ddl=%b busy=%b done=%b ack=%b word=%h line=%b",
                             want.sck, want.data_drive_low, want.busy_res, want.done_res,
                             want.ack_seen, want.read_word, want.line_status);
                    $display("  got sck=%b ddl=%b busy=%b done=%b ack=%b word=%h line=%b",
                             got.sck, got.data_drive_low, got.busy_res, got.done_res,
                             got.ack_seen, got.read_word, got.line_status);
                end
            end
        endfunction

    endclass

endpackage

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-wire sensor bus master.
// ----------------------------------------------------------------------------
// Feeds half-bit ticks into the master and checks every per-tick result
// against a mirrored sequencer. The sensor side is emulated by picking the
// data-pin level from the mirrored state: acknowledge or not, how long the
// line stays low after an acknowledge, and the bits of the word read back.
// A short directed part hits the corner cases, then random transfers run
// under three flow-control profiles.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tsbm_pkg::*;
    import tsbm_tb_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_TICKS   = 630;
    localparam int DRAIN_CYCLES   = 16;
    localparam int TIMEOUT_CYCLES = 200000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // flow-control profile, percent of cycles spent idle / stalled
    int send_gap_pct   = 13;
    int recv_stall_pct = 77;

    int cycle_cnt  = 0;
    int ticks_sent = 0;

    sensor_bus_scoreboard bus_sb;

    always #1 clk = ~clk;

    two_wire_sensor_bus_master i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Watchdog: a hung master (or a lost result) ends the run here.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, bus_sb.expected_bus_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: check on every accepted output transfer, then pick the
    // next ready level. Values sampled here are the ones before the edge.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            bus_sb.check_result(result_t'(m_tdata[21:0]));
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One input transfer. Called at a rising edge; returns at the edge that
    // accepted it. tvalid only drops inside a gap, never between two
    // back-to-back transfers.
    task automatic send_tick(input logic [1:0] req, input logic [7:0] cmd,
                             input logic pin);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, pin, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bus_sb.note_tick(req, cmd, pin);
        ticks_sent++;
    endtask

    // Request tick followed by ticks until the mirrored sequencer is idle.
    // The pin plays the sensor:
    //   ack        - pull the line low in the acknowledge sample slot
    //   hold_low   - ticks the line stays low after an acknowledge
    //   sensor_wd  - word shifted back during a read, MSB first
    //   stray_pct  - chance of a random request code while busy
    // Elsewhere the pin is random, so line_status sees both levels.
    task automatic run_transfer(input logic [1:0] req, input logic [7:0] cmd,
                                input bit ack, input int hold_low,
                                input logic [15:0] sensor_wd, input int stray_pct);
        int         held;
        logic       pin;
        logic [1:0] busy_req;
        held = 0;
        send_tick(req, cmd, 1'($urandom_range(1)));
        while (bus_sb.seq != ST_IDLE) begin
            pin = 1'($urandom_range(1));
            case (bus_sb.seq)
                ST_CACK:
                    if (bus_sb.phase == 3'd2)
                        pin = ~ack;
                ST_WAIT:
                begin
                    pin = (held >= hold_low);
                    held++;
                end
                ST_RBIT:
                    if (bus_sb.phase == 3'd1)
                        pin = sensor_wd[15 - bus_sb.bit_idx];
                default:
                    ;
            endcase
            busy_req = ($urandom_range(99) < stray_pct) ? 2'($urandom_range(3))
                                                         : REQ_CODE_PLAIN;
            send_tick(busy_req, 8'($urandom), pin);
        end
    endtask

    // Mostly complete transfers with random content; some stray ticks,
    // NACKs and long low holds on the data line mixed in.
    task automatic random_transfer();
        int pick;
        int hold;
        pick = $urandom_range(99);
        hold = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(4);
        if (pick < 38)
            run_transfer(REQ_CODE_CMD, 8'($urandom), ($urandom_range(3) != 0), hold,
                         16'd0, 10);
        else if (pick < 76)
            run_transfer(REQ_CODE_READ, 8'($urandom), 1'b0, 0, 16'($urandom), 10);
        else
            send_tick($urandom_range(1) ? REQ_CODE_SPARE : REQ_CODE_PLAIN,
                      8'($urandom), 1'($urandom_range(1)));
    endtask

    initial begin
        int random_base;
        bus_sb = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // plain and unused-code ticks, both line levels
        send_tick(REQ_CODE_PLAIN, 8'h00, 1'b0);
        send_tick(REQ_CODE_SPARE, 8'hFF, 1'b1);
        // all-ones command, acknowledged, line released at once
        run_transfer(REQ_CODE_CMD, 8'hFF, 1'b1, 0, 16'd0, 0);
        // read all ones; ack_seen must stay set through it
        run_transfer(REQ_CODE_READ, 8'h00, 1'b0, 0, 16'hFFFF, 0);
        // all-zeros command, no acknowledge
        run_transfer(REQ_CODE_CMD, 8'h00, 1'b0, 0, 16'd0, 0);
        // read all zeros with requests thrown in while busy
        run_transfer(REQ_CODE_READ, 8'hFF, 1'b0, 0, 16'h0000, 30);
        // silent line: acknowledged, then held low for a long stretch
        run_transfer(REQ_CODE_CMD, 8'hA5, 1'b1, 40, 16'd0, 30);
        // mixed read pattern, MSB and LSB set
        run_transfer(REQ_CODE_READ, 8'h5A, 1'b0, 0, 16'h8C31, 0);

        // --- random part: receiver-heavy gaps, sender-heavy gaps, none ---
        random_base = ticks_sent;
        for (int prof = 0; prof < 3; prof++) begin
            case (prof)
                0:
                begin
                    send_gap_pct   = 13;
                    recv_stall_pct = 77;
                end
                1:
                begin
                    send_gap_pct   = 77;
                    recv_stall_pct = 13;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (ticks_sent < random_base + (prof + 1) * (RANDOM_TICKS / 3))
                random_transfer();
        end
        s_tvalid <= 1'b0;

        // drain, then give the pipeline time to show any stray result
        while (bus_sb.expected_bus_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d ticks sent, %0d results checked, %0d mismatches",
                 ticks_sent, bus_sb.results_checked, bus_sb.mismatches);
        $display("%0d commands (%0d acked), %0d reads, %0d done pulses, %0d busy requests",
                 bus_sb.cmd_starts, bus_sb.acks_taken, bus_sb.read_starts,
                 bus_sb.done_pulses, bus_sb.ignored_reqs);
        if (bus_sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
